/* design/aes128_block_cipher_ecb_cbc_core_assert.svh */
// Assertion macros included by aes_back.
`ifndef AES128_BLOCK_CIPHER_ECB_CBC_CORE_ASSERT_SVH
`define AES128_BLOCK_CIPHER_ECB_CBC_CORE_ASSERT_SVH
`define AES_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define AES_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* design/aes_pkg.sv */
`default_nettype none
package aes_pkg;
  localparam int unsigned BlockW = 128;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned NumRounds = 10;

  typedef enum logic [2:0] {
    CFG_KEY_HIGH = 3'd0,
    CFG_KEY_LOW = 3'd1,
    CFG_IV_HIGH = 3'd2,
    CFG_IV_LOW = 3'd3,
    CFG_CHAIN_MODE = 3'd4,
    CFG_DECRYPT_DIR = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [BlockW-1:0] blk;
    logic first;
  } job_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] byte_of(input logic [BlockW-1:0] s, input int n);
    return s[BlockW-1-8*n -: 8];
  endfunction

  function automatic logic [BlockW-1:0] enc_round(input logic [BlockW-1:0] s,
                                                  input logic last);
    logic [7:0] b [16];
    logic [7:0] a0, a1, a2, a3;
    logic [BlockW-1:0] o;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        b[r + 4 * c] = sbox(byte_of(s, r + 4 * ((c + r) % 4)));
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = b[4 * c]; a1 = b[4 * c + 1]; a2 = b[4 * c + 2]; a3 = b[4 * c + 3];
      if (last) begin
        o[BlockW-1-32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        o[BlockW-1-32*c -: 32] = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                                  a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                                  a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                                  xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
      end
    end
    return o;
  endfunction

  function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] m);
    logic [7:0] a2, a4, a8;
    a2 = xt(a); a4 = xt(a2); a8 = xt(a4);
    return (m[0] ? a : 8'h00) ^ (m[1] ? a2 : 8'h00) ^ (m[2] ? a4 : 8'h00) ^
           (m[3] ? a8 : 8'h00);
  endfunction

  function automatic logic [BlockW-1:0] inv_mix(input logic [BlockW-1:0] s);
    logic [7:0] a0, a1, a2, a3;
    logic [BlockW-1:0] o;
    for (int c = 0; c < 4; c++) begin
      a0 = byte_of(s, 4 * c); a1 = byte_of(s, 4 * c + 1);
      a2 = byte_of(s, 4 * c + 2); a3 = byte_of(s, 4 * c + 3);
      o[BlockW-1-32*c -: 32] = {
        gm(a0, 4'he) ^ gm(a1, 4'hb) ^ gm(a2, 4'hd) ^ gm(a3, 4'h9),
        gm(a0, 4'h9) ^ gm(a1, 4'he) ^ gm(a2, 4'hb) ^ gm(a3, 4'hd),
        gm(a0, 4'hd) ^ gm(a1, 4'h9) ^ gm(a2, 4'he) ^ gm(a3, 4'hb),
        gm(a0, 4'hb) ^ gm(a1, 4'hd) ^ gm(a2, 4'h9) ^ gm(a3, 4'he)};
    end
    return o;
  endfunction

  function automatic logic [BlockW-1:0] inv_sub_shift(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] o;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        o[BlockW-1-8*(r + 4 * ((c + r) % 4)) -: 8] = inv_sbox(byte_of(s, r + 4 * c));
      end
    end
    return o;
  endfunction
endpackage
`default_nettype wire

/* design/aes_if.sv */
`default_nettype none
interface aes_if #(parameter int unsigned W = 128);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/aes128_block_cipher_ecb_cbc_core.sv */
// AES-128 ECB/CBC core.
// The in_ channel carries one 129-bit word: block_high, block_low and first_block
// in the lowest bit. The out_ channel returns one 128-bit result word per input
// word, in order.
// Configure through cfg_we/cfg_idx/cfg_data while no word is in flight: key halves,
// IV halves, chain mode and direction, indices 0 to 5.
// A front queue of two words accepts input while the back end works.
// Each round key is read as four words from the key memory in S_LOAD and the round
// then runs in S_RUN: the back end takes a block in S_IDLE, runs the eleven rounds
// and registers the result in S_DONE. It takes the next word only after that,
// so one block at a time is in the back end. After a key change the next block
// also waits while the key expands.
// Reset clears the queue, the chain value and the configuration registers; the
// key must be expanded again. When the receiver stalls the result is held and the
// back end waits with the next result; the queue keeps accepting until it is full.
`default_nettype none
module aes128_block_cipher_ecb_cbc_core import aes_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input wire logic clk,
  input wire logic rst_n,
  aes_if.sink in_ch,
  aes_if.source out_ch,
  input wire logic cfg_we,
  input wire logic [2:0] cfg_idx,
  input wire logic [63:0] cfg_data
);
  logic q_valid, q_take, fin;
  job_t q_job, in_job;
  logic [BlockW-1:0] blk;
  // The input word carries first_block in its lowest bit.
  assign in_job.blk = in_ch.data[BlockW:1];
  assign in_job.first = in_ch.data[0];
  aes_front #(.DEPTH(DEPTH)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(fin),
    .in_job(in_job), .q_valid(q_valid), .q_take(q_take), .q_job(q_job));
  assign in_ch.ready = fin;
  aes_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data), .q_valid(q_valid), .q_take(q_take), .q_job(q_job),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(blk));
  assign out_ch.data = blk;
endmodule
`default_nettype wire

/* design/aes_ram.sv */
`default_nettype none
module aes_ram #(
  parameter int unsigned W = 32,
  parameter int unsigned D = 44
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(D)-1:0] waddr,
  input wire logic [W-1:0] wdata,
  input wire logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0] rdata
);
  logic [W-1:0] mem_r [D];
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

/* design/aes_front.sv */
`default_nettype none
module aes_front import aes_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  output logic in_ready,
  input wire job_t in_job,
  output logic q_valid,
  input wire logic q_take,
  output job_t q_job
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  job_t q_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;
  logic push;

  assign in_ready = (cnt_r != (AW+1)'(DEPTH));
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != '0);
  assign q_job = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= in_job;
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (q_take) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(q_take);
    end
  end
endmodule
`default_nettype wire

/* design/aes_back.sv */
`default_nettype none
module aes_back import aes_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic cfg_we,
  input wire logic [2:0] cfg_idx,
  input wire logic [63:0] cfg_data,
  input wire logic q_valid,
  output logic q_take,
  input wire job_t q_job,
  output logic out_valid,
  input wire logic out_ready,
  output logic [BlockW-1:0] out_data
);
  typedef enum logic [2:0] {S_IDLE, S_EXP, S_LOAD, S_RUN, S_DONE} st_t;
  st_t st_r;
  logic [63:0] kh_r, kl_r, ivh_r, ivl_r;
  logic cbc_r, dec_r, ready_keys_r;
  logic [BlockW-1:0] chain_r, s_r, cin_r, res_r;
  logic [5:0] ei_r, ra_r;
  logic [2:0] wc_r;
  logic [3:0] rnd_r;
  logic [7:0] rc_r;
  logic [31:0] w_r [4];
  logic [31:0] rk, t, nw;
  logic [BlockW-1:0] key_r;
  logic outv_r, we;
  logic [5:0] waddr;
  job_t job_r;

  aes_ram #(.W(32), .D(44)) u_rk (
    .clk(clk), .we(we), .waddr(waddr), .wdata(nw), .raddr(ra_r), .rdata(rk));

  // Key words are produced one a cycle from a four-word window.
  always_comb begin
    t = w_r[3];
    if (ei_r[1:0] == 2'b00) begin
      t = {sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0]), sbox(t[31:24])} ^ {rc_r, 24'h0};
    end
    nw = (ei_r < 6'd4) ? ((ei_r == 6'd0) ? kh_r[63:32] : (ei_r == 6'd1) ? kh_r[31:0] :
         (ei_r == 6'd2) ? kl_r[63:32] : kl_r[31:0]) : (w_r[0] ^ t);
  end
  assign we = (st_r == S_EXP);
  assign waddr = ei_r;
  assign q_take = (st_r == S_IDLE) && q_valid && ready_keys_r;
  assign out_valid = outv_r;
  assign out_data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      kh_r <= '0; kl_r <= '0; ivh_r <= '0; ivl_r <= '0;
      cbc_r <= 1'b0; dec_r <= 1'b0; ready_keys_r <= 1'b0;
      chain_r <= '0; outv_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_KEY_HIGH: begin kh_r <= cfg_data; ready_keys_r <= 1'b0; end
          CFG_KEY_LOW: begin kl_r <= cfg_data; ready_keys_r <= 1'b0; end
          CFG_IV_HIGH: ivh_r <= cfg_data;
          CFG_IV_LOW: ivl_r <= cfg_data;
          CFG_CHAIN_MODE: cbc_r <= cfg_data[0];
          CFG_DECRYPT_DIR: dec_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (outv_r && out_ready && st_r != S_DONE) begin
        outv_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (q_valid && !ready_keys_r && !cfg_we) begin
            st_r <= S_EXP;
            ei_r <= '0;
            rc_r <= 8'h01;
          end else if (q_take) begin
            job_r <= q_job;
            ra_r <= dec_r ? 6'd40 : 6'd0;
            rnd_r <= '0;
            wc_r <= '0;
            cin_r <= (cbc_r && q_job.first) ? {ivh_r, ivl_r} : chain_r;
            st_r <= S_LOAD;
          end
        end
        S_EXP: begin
          w_r[0] <= w_r[1]; w_r[1] <= w_r[2]; w_r[2] <= w_r[3]; w_r[3] <= nw;
          if (ei_r != 6'd0 && ei_r[1:0] == 2'b00) begin
            rc_r <= xt(rc_r);
          end
          ei_r <= ei_r + 1'b1;
          if (ei_r == 6'd43) begin
            ready_keys_r <= 1'b1;
            st_r <= S_IDLE;
          end
        end
        S_LOAD: begin
          // Read data arrives in the cycle after its address, so the wc_r == 0 step captures no word.
          if (wc_r != 3'd0) begin
            key_r <= {key_r[95:0], rk};
          end
          if (wc_r == 3'd4) begin
            wc_r <= '0;
            st_r <= S_RUN;
            if (rnd_r != 4'(NumRounds)) begin
              ra_r <= dec_r ? ra_r - 6'd7 : ra_r + 6'd1;
            end
          end else begin
            wc_r <= wc_r + 3'd1;
            if (wc_r != 3'd3) begin
              ra_r <= ra_r + 6'd1;
            end
          end
        end
        S_RUN: begin
          if (rnd_r == 4'd0) begin
            s_r <= (dec_r ? job_r.blk : (job_r.blk ^ (cbc_r ? cin_r : '0))) ^ key_r;
          end else if (!dec_r) begin
            s_r <= enc_round(s_r, rnd_r == 4'(NumRounds)) ^ key_r;
          end else if (rnd_r == 4'(NumRounds)) begin
            s_r <= inv_sub_shift(s_r) ^ key_r;
          end else begin
            s_r <= inv_mix(inv_sub_shift(s_r) ^ key_r);
          end
          st_r <= S_LOAD;
          if (rnd_r == 4'(NumRounds)) begin
            st_r <= S_DONE;
          end
          rnd_r <= rnd_r + 1'b1;
        end
        S_DONE: begin
          if (!outv_r || out_ready) begin
            res_r <= dec_r ? (s_r ^ (cbc_r ? cin_r : '0)) : s_r;
            outv_r <= 1'b1;
            if (cbc_r) begin
              chain_r <= dec_r ? job_r.blk : s_r;
            end
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `include "aes128_block_cipher_ecb_cbc_core_assert.svh"
  `AES_ASSERT_IMPL(a_take_keys, q_take, ready_keys_r)
  `AES_ASSERT_NEXT(a_exp_end, st_r == S_EXP && ei_r == 6'd43, ready_keys_r)
  `AES_ASSERT_IMPL(a_no_write_run, st_r == S_RUN, !we)
endmodule
`default_nettype wire

/* verif/tb.sv */
`default_nettype none
module tb;
  import aes_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CFG_SPARE_A = 3'd6;
  localparam logic [2:0] CFG_SPARE_B = 3'd7;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;
  localparam logic [127:0] PLAIN = 128'h00112233445566778899aabbccddeeff;
  localparam logic [127:0] CIPHER = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;

  typedef enum bit {ROW_WRITE, ROW_BLOCK} row_kind_t;
  typedef struct {
    row_kind_t kind;
    logic [2:0] idx;
    logic [63:0] data;
    logic [63:0] hi;
    logic [63:0] lo;
    logic first;
    bit known;
    logic [127:0] result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [63:0] cfg_data = '0;

  aes_if #(.W(129)) in_ch ();
  aes_if #(.W(128)) out_ch ();

  aes128_block_cipher_ecb_cbc_core u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Cipher mirror.
  logic [7:0] fwd_box [256];
  logic [7:0] rev_box [256];
  logic [31:0] key_sched [44];
  logic [63:0] key_hi_m, key_lo_m, iv_hi_m, iv_lo_m;
  logic cbc_m, dec_m, sched_valid;
  logic [127:0] chain_m;

  logic [127:0] block_q [$];
  logic [128:0] typed_q [$];
  int in_count = 0;
  int out_count = 0;
  int errors = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) r ^= a;
      a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
      b = b >> 1;
    end
    return r;
  endfunction

  function automatic void expand_sched();
    logic [31:0] t;
    logic [7:0] rc;
    key_sched[0] = key_hi_m[63:32];
    key_sched[1] = key_hi_m[31:0];
    key_sched[2] = key_lo_m[63:32];
    key_sched[3] = key_lo_m[31:0];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = key_sched[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {fwd_box[t[31:24]], fwd_box[t[23:16]], fwd_box[t[15:8]], fwd_box[t[7:0]]};
        t ^= {rc, 24'h0};
        rc = gf_mul(rc, 8'h02);
      end
      key_sched[i] = key_sched[i-4] ^ t;
    end
    sched_valid = 1'b1;
  endfunction

  function automatic logic [127:0] add_key(input logic [127:0] s, input int rnd);
    for (int c = 0; c < 4; c++) s[127-32*c -: 32] ^= key_sched[4*rnd+c];
    return s;
  endfunction

  function automatic logic [127:0] sub_all(input logic [127:0] s, input bit inv);
    for (int n = 0; n < 16; n++)
      s[127-8*n -: 8] = inv ? rev_box[s[127-8*n -: 8]] : fwd_box[s[127-8*n -: 8]];
    return s;
  endfunction

  function automatic logic [127:0] shift_all(input logic [127:0] s, input bit inv);
    logic [127:0] o;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        if (inv) o[127-8*(r+4*((c+r)%4)) -: 8] = s[127-8*(r+4*c) -: 8];
        else o[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)%4)) -: 8];
      end
    return o;
  endfunction

  function automatic logic [127:0] mix_all(input logic [127:0] s, input bit inv);
    logic [7:0] coef [4];
    logic [7:0] col [4];
    logic [7:0] v;
    if (inv) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else coef = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) col[k] = s[127-8*(4*c+k) -: 8];
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) v ^= gf_mul(coef[(k-r+4)%4], col[k]);
        s[127-8*(4*c+r) -: 8] = v;
      end
    end
    return s;
  endfunction

  function automatic logic [127:0] aes_block(input logic [127:0] s, input bit inv);
    if (!inv) begin
      s = add_key(s, 0);
      for (int rnd = 1; rnd <= 10; rnd++) begin
        s = shift_all(sub_all(s, 1'b0), 1'b0);
        if (rnd < 10) s = mix_all(s, 1'b0);
        s = add_key(s, rnd);
      end
    end else begin
      s = add_key(s, 10);
      for (int rnd = 9; rnd >= 0; rnd--) begin
        s = add_key(sub_all(shift_all(s, 1'b1), 1'b1), rnd);
        if (rnd > 0) s = mix_all(s, 1'b1);
      end
    end
    return s;
  endfunction

  function automatic logic [127:0] cipher_word(input logic [127:0] blk, input logic first);
    logic [127:0] r;
    if (!sched_valid) expand_sched();
    if (cbc_m && first) chain_m = {iv_hi_m, iv_lo_m};
    if (!dec_m) begin
      r = aes_block(cbc_m ? (blk ^ chain_m) : blk, 1'b0);
      if (cbc_m) chain_m = r;
    end else begin
      r = aes_block(blk, 1'b1);
      if (cbc_m) begin
        r ^= chain_m;
        chain_m = blk;
      end
    end
    return r;
  endfunction

  initial begin
    logic [7:0] inv, b;
    for (int a = 0; a < 256; a++) begin
      inv = 8'h00;
      for (int x = 1; x < 256; x++)
        if (a != 0 && gf_mul(a[7:0], x[7:0]) == 8'h01) inv = x[7:0];
      b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]} ^
          {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_box[a] = b;
      rev_box[b] = a[7:0];
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    logic [127:0] r;
    logic [128:0] typed;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      r = cipher_word(in_ch.data[128:1], in_ch.data[0]);
      typed = typed_q.pop_front();
      if (typed[128]) r = typed[127:0];
      block_q.insert(block_q.size(), r);
      in_count++;
    end
  end

  always @(posedge clk) begin
    logic [127:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      out_count++;
      if (block_q.size() == 0) begin
        report_mismatch("unexpected word", out_ch.data[127:64], 64'h0);
      end else begin
        want = block_q.pop_front();
        if (out_ch.data[127:64] !== want[127:64])
          report_mismatch("out_high", out_ch.data[127:64], want[127:64]);
        if (out_ch.data[63:0] !== want[63:0])
          report_mismatch("out_low", out_ch.data[63:0], want[63:0]);
      end
    end
  end

  always @(posedge clk) begin
    int last_total, quiet;
    if (in_count + out_count != last_total) begin
      last_total = in_count + out_count;
      quiet = 0;
    end else if (rst_n) begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("FAIL aes128_block_cipher_ecb_cbc_core");
        $finish;
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_word(input logic [63:0] hi, input logic [63:0] lo, input logic first,
                           input bit known, input logic [127:0] result);
    int seen;
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    typed_q.insert(typed_q.size(), {known, result});
    in_ch.data = {hi, lo, first};
    in_ch.valid = 1'b1;
    seen = in_count;
    do @(negedge clk); while (in_count == seen);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    do @(negedge clk); while (block_q.size() != 0);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = data;
    case (idx)
      CFG_KEY_HIGH: begin key_hi_m = data; sched_valid = 1'b0; end
      CFG_KEY_LOW: begin key_lo_m = data; sched_valid = 1'b0; end
      CFG_IV_HIGH: iv_hi_m = data;
      CFG_IV_LOW: iv_lo_m = data;
      CFG_CHAIN_MODE: cbc_m = data[0];
      CFG_DECRYPT_DIR: dec_m = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [63:0] pick64();
    case ($urandom_range(7))
      0: return 64'h0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic run_phase(input int n, input int gap, input int stall, input bit hold);
    int msg_left;
    logic first;
    drain();
    if ($urandom_range(3) != 0) begin
      write_reg(CFG_KEY_HIGH, pick64());
      write_reg(CFG_KEY_LOW, pick64());
    end
    write_reg(CFG_IV_HIGH, pick64());
    write_reg(CFG_IV_LOW, pick64());
    write_reg(CFG_CHAIN_MODE, {$urandom, $urandom});
    write_reg(CFG_DECRYPT_DIR, {$urandom, $urandom});
    gap_pct = gap;
    stall_pct = stall;
    if (hold) hold_left = HOLD_CYCLES;
    msg_left = 0;
    for (int i = 0; i < n; i++) begin
      if (msg_left == 0) begin
        msg_left = $urandom_range(8, 1);
        first = 1'b1;
      end else begin
        first = 1'b0;
      end
      msg_left--;
      if ($urandom_range(9) == 0) first = 1'($urandom_range(1));
      send_word(pick64(), pick64(), first, 1'b0, '0);
    end
    gap_pct = 0;
    stall_pct = 0;
  endtask

  stim_row_t plan [$];

  function automatic void add_write(input logic [2:0] idx, input logic [63:0] data);
    plan.insert(plan.size(), '{ROW_WRITE, idx, data, '0, '0, 1'b0, 1'b0, '0});
  endfunction

  function automatic void add_block(input logic [63:0] hi, input logic [63:0] lo,
                                    input logic first, input bit known,
                                    input logic [127:0] result);
    plan.insert(plan.size(), '{ROW_BLOCK, '0, '0, hi, lo, first, known, result});
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    key_hi_m = '0; key_lo_m = '0; iv_hi_m = '0; iv_lo_m = '0;
    cbc_m = 1'b0; dec_m = 1'b0; sched_valid = 1'b0; chain_m = '0;

    add_block('0, '0, 1'b0, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e);
    add_block('1, '1, 1'b1, 1'b0, '0);
    add_write(CFG_KEY_HIGH, 64'h0001020304050607);
    add_write(CFG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    add_block(PLAIN[127:64], PLAIN[63:0], 1'b0, 1'b1, CIPHER);
    add_write(CFG_DECRYPT_DIR, 64'h1);
    add_block(CIPHER[127:64], CIPHER[63:0], 1'b0, 1'b1, PLAIN);
    add_write(CFG_DECRYPT_DIR, 64'hfffffffffffffffe);
    add_block(PLAIN[127:64], PLAIN[63:0], 1'b1, 1'b1, CIPHER);
    add_write(CFG_CHAIN_MODE, 64'h1);
    add_block(PLAIN[127:64], PLAIN[63:0], 1'b0, 1'b1, CIPHER);
    add_block(PLAIN[127:64], PLAIN[63:0], 1'b0, 1'b0, '0);
    add_write(CFG_IV_HIGH, 64'h0f1e2d3c4b5a6978);
    add_write(CFG_IV_LOW, 64'h8796a5b4c3d2e1f0);
    add_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1, 1'b0, '0);
    add_block(64'h8000000000000000, 64'h0000000000000001, 1'b0, 1'b0, '0);
    add_block('1, '0, 1'b0, 1'b0, '0);
    add_write(CFG_DECRYPT_DIR, 64'h1);
    add_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 1'b0, '0);
    add_block('0, '1, 1'b0, 1'b0, '0);
    add_write(CFG_SPARE_A, '1);
    add_write(CFG_SPARE_B, '1);
    add_block(64'h1234567812345678, 64'h9abcdef09abcdef0, 1'b1, 1'b0, '0);
    add_block(64'h0badc0de0badc0de, 64'hdeadbeefdeadbeef, 1'b0, 1'b0, '0);
    add_write(CFG_CHAIN_MODE, 64'h2);
    add_block(CIPHER[127:64], CIPHER[63:0], 1'b1, 1'b1, PLAIN);
    add_write(CFG_KEY_HIGH, '1);
    add_write(CFG_KEY_LOW, '1);
    add_block('0, '0, 1'b0, 1'b0, '0);
    add_block('1, '1, 1'b1, 1'b0, '0);
    add_write(CFG_CHAIN_MODE, 64'h1);
    add_write(CFG_DECRYPT_DIR, 64'h0);
    add_block('1, '1, 1'b1, 1'b0, '0);
    add_block('0, '0, 1'b0, 1'b0, '0);

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        if (i == 0 || plan[i-1].kind != ROW_WRITE) drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_word(plan[i].hi, plan[i].lo, plan[i].first, plan[i].known, plan[i].result);
      end
    end

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: run_phase(50, 0, 0, p == 4);
        1: run_phase(50, 53, 0, 1'b0);
        2: run_phase(50, 0, 53, p == 2);
        default: run_phase(50, 37, 37, 1'b0);
      endcase
    end

    drain();
    if (errors == 0) begin
      $display("PASS aes128_block_cipher_ecb_cbc_core");
    end else begin
      $display("FAIL aes128_block_cipher_ecb_cbc_core");
    end
    $finish;
  end
endmodule
`default_nettype wire
